[rtl/stl_pkg.sv]
package stl_pkg;

   localparam int PositionBitsDefault = 24;
   localparam int KeywordCharsDefault = 6;
   localparam int LineBits = 24;
   localparam int MaxRecords = 3;

   localparam logic [4:0] KindIdent   = 5'd0;
   localparam logic [4:0] KindKeyword = 5'd1;
   localparam logic [4:0] KindNumber  = 5'd2;
   localparam logic [4:0] KindString  = 5'd3;
   localparam logic [4:0] KindChar    = 5'd4;
   localparam logic [4:0] KindAssign  = 5'd10;
   localparam logic [4:0] KindMinus   = 5'd11;
   localparam logic [4:0] KindSlash   = 5'd13;
   localparam logic [4:0] KindLt      = 5'd15;
   localparam logic [4:0] KindLe      = 5'd16;
   localparam logic [4:0] KindGt      = 5'd17;
   localparam logic [4:0] KindGe      = 5'd18;
   localparam logic [4:0] KindEqEq    = 5'd22;
   localparam logic [4:0] KindNe      = 5'd23;
   localparam logic [4:0] KindAndAnd  = 5'd24;
   localparam logic [4:0] KindOrOr    = 5'd25;
   localparam logic [4:0] KindEnd     = 5'd27;

   localparam logic [2:0] ErrNone       = 3'd0;
   localparam logic [2:0] ErrSymbol     = 3'd1;
   localparam logic [2:0] ErrString     = 3'd2;
   localparam logic [2:0] ErrCharLit    = 3'd3;
   localparam logic [2:0] ErrEndOfText  = 3'd4;

   typedef enum logic [4:0] {
      MODE_IDLE, MODE_IDENT, MODE_NUMBER, MODE_MINUS, MODE_SLASH, MODE_COMMENT,
      MODE_STRING, MODE_CH_OPEN, MODE_CH_ESC, MODE_CH_CLOSE, MODE_LT, MODE_GT,
      MODE_EQ, MODE_AMP, MODE_BAR, MODE_BANG, MODE_HALT
   } mode_type;

   // one token record, start position field at full 32-bit span and cut at the top
   typedef struct packed {
      logic [4:0]  kind;
      logic [2:0]  err;
      logic [23:0] line;
      logic [31:0] start;
      logic [23:0] len;
      logic [3:0]  kw;
      logic [7:0]  lit1;
      logic [7:0]  lit2;
      logic        last;
   } record_type;

   // group of up to three records caused by one byte
   typedef struct packed {
      logic [1:0]                    count;
      record_type [MaxRecords-1:0]   rec;
   } bundle_type;

   function automatic logic [63:0] keyword_packed(input logic [3:0] idx);
      logic [63:0] r;
      r = '0;
      unique case (idx)
         4'd0: r = 64'h666e;
         4'd1: r = 64'h6966;
         4'd2: r = 64'h656c7365;
         4'd3: r = 64'h7768696c65;
         4'd4: r = 64'h666f72;
         4'd5: r = 64'h72657475726e;
         4'd6: r = 64'h6e756c6c;
         4'd7: r = 64'h7265636f7264;
         4'd8: r = 64'h616c6c6f63;
         4'd9: r = 64'h73697a656f66;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] keyword_len(input logic [3:0] idx);
      logic [3:0] r;
      r = '0;
      unique case (idx)
         4'd0, 4'd1: r = 4'd2;
         4'd4: r = 4'd3;
         4'd2, 4'd6: r = 4'd4;
         4'd3, 4'd8: r = 4'd5;
         4'd5, 4'd7, 4'd9: r = 4'd6;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] single_kind(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      case (c)
         8'h28: r = 5'd5;
         8'h29: r = 5'd6;
         8'h7b: r = 5'd7;
         8'h7d: r = 5'd8;
         8'h3b: r = 5'd9;
         8'h2b: r = 5'd12;
         8'h2a: r = 5'd14;
         8'h2c: r = 5'd19;
         8'h5b: r = 5'd20;
         8'h5d: r = 5'd21;
         8'h2e: r = 5'd26;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

[rtl/source_text_lexer_core.sv]
// channel   direction  handshake        payload
// req_      in         push / full      text_byte, end_of_text
// rsp_      out        pop / empty      token record fields
//
// one byte is taken per cycle while full is low; a byte yields zero to three records
// records pass through a queue and leave one per cycle through pop
// full rises when the queue lacks room for three more records
// synchronous reset returns to line 1, offset 0 and an empty queue
module source_text_lexer_core #(
   parameter int POSITION_BITS = stl_pkg::PositionBitsDefault,
   parameter int KEYWORD_CHARS = stl_pkg::KeywordCharsDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_text_byte,
   input  logic        req_end_of_text,
   output logic        empty,
   input  logic        pop,
   output logic [4:0]  rsp_token_kind,
   output logic [2:0]  rsp_error_code,
   output logic [23:0] rsp_line_number,
   output logic [23:0] rsp_start_offset,
   output logic [23:0] rsp_token_length,
   output logic [3:0]  rsp_keyword_index,
   output logic [7:0]  rsp_literal_first,
   output logic [7:0]  rsp_literal_second,
   output logic        rsp_last_of_run
);
   import stl_pkg::*;

   localparam int Depth = 8;
   localparam int AddrBits = $clog2(Depth);

   bundle_type  bundle;
   logic        take;
   record_type  q_ff [Depth];
   logic [AddrBits-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AddrBits:0]   cnt_ff, cnt_in;
   logic        deq;
   record_type  head;

   assign take = push && !full;

   stl_front #(.POSITION_BITS(POSITION_BITS), .KEYWORD_CHARS(KEYWORD_CHARS)) u_front (
      .clock(clock), .reset(reset), .in_valid(take), .in_byte(req_text_byte),
      .in_last(req_end_of_text), .out_bundle(bundle)
   );

   assign full  = cnt_ff > (AddrBits+1)'(Depth - MaxRecords);
   assign empty = cnt_ff == '0;
   assign deq   = pop && !empty;
   assign head  = q_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff + AddrBits'(bundle.count);
      rd_in  = rd_ff + AddrBits'(deq);
      cnt_in = cnt_ff + (AddrBits+1)'(bundle.count) - (AddrBits+1)'(deq);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MaxRecords; i++)
         if (2'(i) < bundle.count) q_ff[wr_ff + AddrBits'(i)] <= bundle.rec[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in; rd_ff <= rd_in; cnt_ff <= cnt_in;
      end
   end

   assign rsp_token_kind     = head.kind;
   assign rsp_error_code     = head.err;
   assign rsp_line_number    = head.line;
   assign rsp_start_offset   = head.start[23:0];
   assign rsp_token_length   = head.len;
   assign rsp_keyword_index  = head.kw;
   assign rsp_literal_first  = head.lit1;
   assign rsp_literal_second = head.lit2;
   assign rsp_last_of_run    = head.last;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AddrBits+1)'(Depth)) else $error("queue overflow");
   a_no_out_when_idle: assert property (@(posedge clock) disable iff (reset)
      !take |-> bundle.count == 2'd0) else $error("record without transaction");
   a_last_ends_text: assert property (@(posedge clock) disable iff (reset)
      take && req_end_of_text |-> bundle.count != 2'd0) else $error("missing end record");

endmodule

[rtl/stl_front.sv]
module stl_front #(
   parameter int POSITION_BITS = stl_pkg::PositionBitsDefault,
   parameter int KEYWORD_CHARS = stl_pkg::KeywordCharsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [7:0]            in_byte,
   input  logic                  in_last,
   output stl_pkg::bundle_type   out_bundle
);
   import stl_pkg::*;

   localparam int WinBits = 8 * KEYWORD_CHARS;
   localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};

   mode_type               mode_ff, mode_in;
   logic [LineBits-1:0]    line_ff, line_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] tstart_ff, tstart_in;
   logic [LineBits-1:0]    vlen_ff, vlen_in;
   logic [WinBits-1:0]     win_ff, win_in;
   logic [15:0]            lit_ff, lit_in;

   logic       is_alpha, is_digit, is_ws;
   logic [4:0] sk;
   logic [POSITION_BITS-1:0] after, pos_next;
   logic [LineBits-1:0] vlen_inc, line_inc;
   logic [4:0] word_kind;
   logic [3:0] word_idx;
   logic       reidle;
   logic [1:0] n;
   record_type r [MaxRecords];
   logic [LineBits-1:0] emit_line;

   function automatic logic [LineBits-1:0] sat(input logic [LineBits-1:0] v);
      return (&v) ? v : v + 1'b1;
   endfunction

   function automatic record_type mk(input logic [4:0] k, input logic [2:0] e,
                                     input logic [LineBits-1:0] ln,
                                     input logic [POSITION_BITS-1:0] s,
                                     input logic [LineBits-1:0] l, input logic [3:0] kw,
                                     input logic [7:0] a, input logic [7:0] b);
      record_type t;
      t.kind = k; t.err = e; t.line = ln;
      t.start = 32'(s); t.len = l; t.kw = kw; t.lit1 = a; t.lit2 = b; t.last = 1'b0;
      return t;
   endfunction

   // keyword match in parallel over all ten entries, gives {kind, index}
   function automatic logic [8:0] word_class(input logic [WinBits-1:0] win,
                                             input logic [LineBits-1:0] vlen);
      logic [63:0] w;
      logic [63:0] msk;
      logic [3:0]  kl;
      logic [4:0]  k;
      logic [3:0]  idx;
      k   = KindIdent;
      idx = '0;
      w = 64'(win);
      for (int i = 9; i >= 0; i--) begin
         kl = keyword_len(4'(i));
         msk = (64'd1 << (8 * kl)) - 64'd1;
         if (vlen == LineBits'(kl) && kl <= 4'(KEYWORD_CHARS)
             && (w & msk) == keyword_packed(4'(i))) begin
            k   = KindKeyword;
            idx = 4'(i);
         end
      end
      return {k, idx};
   endfunction

   assign {word_kind, word_idx} = word_class(win_ff, vlen_ff);

   always_comb begin
      logic [4:0] fl_kind;
      logic [3:0] fl_idx;
      is_alpha = (in_byte >= 8'h41 && in_byte <= 8'h5a) || (in_byte >= 8'h61 && in_byte <= 8'h7a);
      is_digit = in_byte >= 8'h30 && in_byte <= 8'h39;
      is_ws    = in_byte == 8'h20 || in_byte == 8'h09;
      sk       = single_kind(in_byte);
      after    = (pos_ff == PosMax) ? PosMax : pos_ff + 1'b1;
      pos_next = after;
      vlen_inc = sat(vlen_ff);
      line_inc = sat(line_ff);

      mode_in = mode_ff; line_in = line_ff; pos_in = pos_ff; tstart_in = tstart_ff;
      vlen_in = vlen_ff; win_in = win_ff; lit_in = lit_ff;
      n = '0;
      for (int i = 0; i < MaxRecords; i++) r[i] = '0;
      reidle = 1'b0;
      emit_line = line_ff;
      fl_kind = KindIdent;
      fl_idx  = '0;

      if (in_valid) begin
         pos_in = pos_next;
         unique case (mode_ff)
            MODE_IDLE: reidle = 1'b1;
            MODE_IDENT: begin
               if (is_alpha || is_digit) begin
                  vlen_in = vlen_inc;
                  win_in = WinBits'({win_ff, in_byte});
               end else begin
                  r[n] = mk(word_kind, ErrNone, line_ff, tstart_ff, vlen_ff, word_idx, '0, '0);
                  n = n + 1'b1; reidle = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_digit) vlen_in = vlen_inc;
               else begin
                  r[n] = mk(KindNumber, ErrNone, line_ff, tstart_ff, vlen_ff, '0, '0, '0);
                  n = n + 1'b1; reidle = 1'b1;
               end
            end
            MODE_MINUS: begin
               if (is_digit) begin
                  mode_in = MODE_NUMBER; vlen_in = LineBits'(2);
               end else begin
                  r[n] = mk(KindMinus, ErrNone, line_ff, tstart_ff, LineBits'(1), '0, '0, '0);
                  n = n + 1'b1; reidle = 1'b1;
               end
            end
            MODE_SLASH: begin
               if (in_byte == 8'h2f) mode_in = MODE_COMMENT;
               else begin
                  r[n] = mk(KindSlash, ErrNone, line_ff, tstart_ff, LineBits'(1), '0, '0, '0);
                  n = n + 1'b1; reidle = 1'b1;
               end
            end
            MODE_COMMENT: if (in_byte == 8'h0a) reidle = 1'b1;
            MODE_STRING: begin
               if (in_byte == 8'h22) begin
                  r[n] = mk(KindString, ErrNone, line_ff, tstart_ff, vlen_ff, '0, '0, '0);
                  n = n + 1'b1; mode_in = MODE_IDLE;
               end else vlen_in = vlen_inc;
            end
            MODE_CH_OPEN: begin
               lit_in = {in_byte, 8'h00}; vlen_in = LineBits'(1);
               mode_in = (in_byte == 8'h5c) ? MODE_CH_ESC : MODE_CH_CLOSE;
            end
            MODE_CH_ESC: begin
               lit_in = {lit_ff[15:8], in_byte}; vlen_in = LineBits'(2);
               mode_in = MODE_CH_CLOSE;
            end
            MODE_CH_CLOSE: begin
               if (in_byte == 8'h27) begin
                  r[n] = mk(KindChar, ErrNone, line_ff, tstart_ff, vlen_ff, '0,
                            lit_ff[15:8], lit_ff[7:0]);
                  n = n + 1'b1; mode_in = MODE_IDLE;
               end else begin
                  r[n] = mk(KindEnd, ErrCharLit, line_ff, tstart_ff, '0, '0, '0, '0);
                  n = n + 1'b1; mode_in = MODE_HALT;
               end
            end
            MODE_LT, MODE_GT, MODE_EQ: begin
               if (in_byte == 8'h3d) begin
                  r[n] = mk((mode_ff == MODE_LT) ? KindLe : (mode_ff == MODE_GT) ? KindGe
                            : KindEqEq, ErrNone, line_ff, tstart_ff, LineBits'(2), '0, '0, '0);
                  n = n + 1'b1; mode_in = MODE_IDLE;
               end else begin
                  r[n] = mk((mode_ff == MODE_LT) ? KindLt : (mode_ff == MODE_GT) ? KindGt
                            : KindAssign, ErrNone, line_ff, tstart_ff, LineBits'(1), '0, '0, '0);
                  n = n + 1'b1; reidle = 1'b1;
               end
            end
            MODE_AMP, MODE_BAR, MODE_BANG: begin
               if ((mode_ff == MODE_AMP && in_byte == 8'h26) ||
                   (mode_ff == MODE_BAR && in_byte == 8'h7c) ||
                   (mode_ff == MODE_BANG && in_byte == 8'h3d)) begin
                  r[n] = mk((mode_ff == MODE_AMP) ? KindAndAnd : (mode_ff == MODE_BAR)
                            ? KindOrOr : KindNe, ErrNone, line_ff, tstart_ff,
                            LineBits'(2), '0, '0, '0);
                  n = n + 1'b1; mode_in = MODE_IDLE;
               end else begin
                  r[n] = mk(KindEnd, ErrSymbol, line_ff, tstart_ff, '0, '0, '0, '0);
                  n = n + 1'b1; mode_in = MODE_HALT;
               end
            end
            MODE_HALT: ;
            default: reidle = 1'b1;
         endcase

         if (reidle) begin
            mode_in = MODE_IDLE;
            tstart_in = pos_ff;
            if (is_ws) ;
            else if (in_byte == 8'h0a) line_in = line_inc;
            else if (is_alpha) begin
               mode_in = MODE_IDENT; vlen_in = LineBits'(1); win_in = WinBits'(in_byte);
            end else if (is_digit) begin
               mode_in = MODE_NUMBER; vlen_in = LineBits'(1);
            end else begin
               case (in_byte)
                  8'h2f: begin mode_in = MODE_SLASH; vlen_in = LineBits'(1); end
                  8'h2d: begin mode_in = MODE_MINUS; vlen_in = LineBits'(1); end
                  8'h22: begin mode_in = MODE_STRING; tstart_in = after; vlen_in = '0; end
                  8'h27: begin
                     mode_in = MODE_CH_OPEN; tstart_in = after; vlen_in = '0; lit_in = '0;
                  end
                  8'h3c: begin mode_in = MODE_LT; vlen_in = LineBits'(1); end
                  8'h3e: begin mode_in = MODE_GT; vlen_in = LineBits'(1); end
                  8'h3d: begin mode_in = MODE_EQ; vlen_in = LineBits'(1); end
                  8'h26: begin mode_in = MODE_AMP; vlen_in = LineBits'(1); end
                  8'h7c: begin mode_in = MODE_BAR; vlen_in = LineBits'(1); end
                  8'h21: begin mode_in = MODE_BANG; vlen_in = LineBits'(1); end
                  default: begin
                     if (sk != 5'd0) begin
                        r[n] = mk(sk, ErrNone, line_ff, pos_ff, LineBits'(1), '0, '0, '0);
                        n = n + 1'b1;
                     end else begin
                        r[n] = mk(KindEnd, ErrSymbol, line_ff, pos_ff, '0, '0, '0, '0);
                        n = n + 1'b1; mode_in = MODE_HALT;
                     end
                  end
               endcase
            end
         end

         // end of text: close the pending token with the state after this byte
         if (in_last) begin
            emit_line = line_in;
            {fl_kind, fl_idx} = word_class(win_in, vlen_in);
            unique case (mode_in)
               MODE_IDENT: begin
                  r[n] = mk(fl_kind, ErrNone, emit_line, tstart_in, vlen_in, fl_idx, '0, '0);
                  n = n + 1'b1;
               end
               MODE_NUMBER: begin
                  r[n] = mk(KindNumber, ErrNone, emit_line, tstart_in, vlen_in, '0, '0, '0);
                  n = n + 1'b1;
               end
               MODE_MINUS, MODE_SLASH, MODE_LT, MODE_GT, MODE_EQ: begin
                  r[n] = mk((mode_in == MODE_MINUS) ? KindMinus : (mode_in == MODE_SLASH)
                            ? KindSlash : (mode_in == MODE_LT) ? KindLt
                            : (mode_in == MODE_GT) ? KindGt : KindAssign,
                            ErrNone, emit_line, tstart_in, LineBits'(1), '0, '0, '0);
                  n = n + 1'b1;
               end
               MODE_STRING: begin
                  r[n] = mk(KindEnd, ErrString, emit_line, tstart_in, '0, '0, '0, '0);
                  n = n + 1'b1;
               end
               MODE_CH_OPEN, MODE_CH_ESC: begin
                  r[n] = mk(KindEnd, ErrEndOfText, emit_line, tstart_in, '0, '0, '0, '0);
                  n = n + 1'b1;
               end
               MODE_CH_CLOSE: begin
                  r[n] = mk(KindEnd, ErrCharLit, emit_line, tstart_in, '0, '0, '0, '0);
                  n = n + 1'b1;
               end
               MODE_AMP, MODE_BAR, MODE_BANG: begin
                  r[n] = mk(KindEnd, ErrSymbol, emit_line, tstart_in, '0, '0, '0, '0);
                  n = n + 1'b1;
               end
               default: ;
            endcase
            r[n] = mk(KindEnd, ErrNone, emit_line, pos_next, '0, '0, '0, '0);
            n = n + 1'b1;
            mode_in = MODE_IDLE; line_in = LineBits'(1); pos_in = '0; tstart_in = '0;
            vlen_in = '0; win_in = '0; lit_in = '0;
         end
         if (n != 2'd0) r[n - 1'b1].last = 1'b1;
      end

      out_bundle.count = n;
      for (int i = 0; i < MaxRecords; i++) out_bundle.rec[i] = r[i];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE; line_ff <= LineBits'(1); pos_ff <= '0; tstart_ff <= '0;
         vlen_ff <= '0; win_ff <= '0; lit_ff <= '0;
      end else begin
         mode_ff <= mode_in; line_ff <= line_in; pos_ff <= pos_in; tstart_ff <= tstart_in;
         vlen_ff <= vlen_in; win_ff <= win_in; lit_ff <= lit_in;
      end
   end

endmodule
